// ----- sv/lrl_pkg.sv -----
// Package with the shared types, constants and helper functions of the LRU replacement list.
`timescale 1ns / 1ps

package lrl_pkg;

  // Size of the entry table and the field widths.
  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = 7;
  localparam int unsigned AddrW     = 48;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [AddrW-1:0] addr_t;

  // Request beat.
  typedef struct packed {
    logic  mode;
    idx_t  hit_entry;
    addr_t source_addr;
  } lrl_in_t;

  // Result beat.
  typedef struct packed {
    idx_t  chosen_entry;
    logic  fill_needed;
    addr_t fill_addr;
    logic  bad_entry;
  } lrl_out_t;

  // Request modes.
  localparam logic ModeHit  = 1'b0;
  localparam logic ModeMiss = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the request beat
    logic rd_issue;  // read the links of the chosen entry, hook it behind the MRU end
    logic link_wr;   // close the gap the chosen entry leaves
    logic tail_wr;   // make the chosen entry the MRU end
    logic load_out;  // load the result register
  } lrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic skip;      // bad hit or hit on the MRU entry: the order stays as it is
    logic out_free;  // the result register can take a new beat
  } lrl_sts_t;

  // Clamp the written entry count to 1 .. MaxBlocks.
  function automatic cnt_t eff_count(cnt_t v);
    cnt_t r;
    r = v;
    if (v == '0) begin
      r = cnt_t'(1);
    end else if (v > cnt_t'(MaxBlocks)) begin
      r = cnt_t'(MaxBlocks);
    end
    return r;
  endfunction

  // Link toward more recently used in the initial order.
  function automatic idx_t dflt_next(idx_t i);
    idx_t r;
    r = (i == '0) ? '0 : idx_t'(i - 1'b1);
    return r;
  endfunction

  // Link toward less recently used in the initial order for n entries.
  function automatic idx_t dflt_prev(idx_t i, cnt_t n);
    cnt_t ip1;
    ip1 = cnt_t'(i) + cnt_t'(1);
    return (ip1 < n) ? ip1[IdxW-1:0] : i;
  endfunction

endpackage

// ----- sv/lrl_ctrl.sv -----
// Controller state machine that sequences the relinking of one request.
`timescale 1ns / 1ps

module lrl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrl_pkg::lrl_sts_t sts_i,
  output lrl_pkg::lrl_cmd_t cmd_o
);
  import lrl_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_LINK = 5'b00100,
    S_TAIL = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.skip) begin
          state_d = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_LINK;
        end
      end
      S_LINK: begin
        cmd_o.link_wr = 1'b1;
        state_d       = S_TAIL;
      end
      S_TAIL: begin
        cmd_o.tail_wr = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/lrl_dp.sv -----
// Datapath with the link memories, the list ends, the request register and the result register.
`timescale 1ns / 1ps

module lrl_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lrl_pkg::cnt_t     cfg_data_i,
  input  lrl_pkg::lrl_in_t  in_data_i,
  input  lrl_pkg::lrl_cmd_t cmd_i,
  output lrl_pkg::lrl_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrl_pkg::lrl_out_t out_data_o
);
  import lrl_pkg::*;

  // Configuration and list ends.
  cnt_t count_q;
  idx_t lru_q, lru_d;
  idx_t mru_q, mru_d;

  // Request held while it is worked on.
  lrl_in_t item_q;
  idx_t    ent_q;
  logic    bad_q;

  // Link memories with valid bits; an entry not yet written reads as the initial order.
  idx_t                 nxt_mem [MaxBlocks];
  idx_t                 prv_mem [MaxBlocks];
  logic [MaxBlocks-1:0] nxt_vld_q;
  logic [MaxBlocks-1:0] prv_vld_q;
  idx_t                 nxt_rd_q, prv_rd_q;
  logic                 nxt_rv_q, prv_rv_q;

  logic nxt_we, prv_we;
  idx_t nxt_wa, nxt_wd, prv_wa, prv_wd;
  idx_t nx, pv;
  logic ent_is_lru;

  // Result register.
  logic     out_valid_q;
  lrl_out_t out_q;

  // Neighbors of the chosen entry, falling back to the initial order.
  assign nx         = nxt_rv_q ? nxt_rd_q : dflt_next(ent_q);
  assign pv         = prv_rv_q ? prv_rd_q : dflt_prev(ent_q, count_q);
  assign ent_is_lru = (ent_q == lru_q);

  assign sts_o.skip     = bad_q || (ent_q == mru_q);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Request capture: the chosen entry is fixed when the beat is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_data_i;
      ent_q  <= (in_data_i.mode == ModeMiss) ? lru_q : in_data_i.hit_entry;
      bad_q  <= (in_data_i.mode == ModeHit) &&
                (cnt_t'(in_data_i.hit_entry) >= count_q);
    end
  end

  // Write port selection for both link memories.
  always_comb begin
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = '0;
    prv_we = 1'b0;
    prv_wa = '0;
    prv_wd = '0;
    lru_d  = lru_q;
    mru_d  = mru_q;
    if (cmd_i.rd_issue) begin
      nxt_we = 1'b1;
      nxt_wa = mru_q;
      nxt_wd = ent_q;
    end
    if (cmd_i.link_wr) begin
      prv_we = 1'b1;
      prv_wa = nx;
      if (ent_is_lru) begin
        prv_wd = nx;
        lru_d  = nx;
      end else begin
        prv_wd = pv;
        nxt_we = 1'b1;
        nxt_wa = pv;
        nxt_wd = nx;
      end
    end
    if (cmd_i.tail_wr) begin
      nxt_we = 1'b1;
      nxt_wa = ent_q;
      nxt_wd = ent_q;
      prv_we = 1'b1;
      prv_wa = ent_q;
      prv_wd = mru_q;
      mru_d  = ent_q;
    end
  end

  // Next-link memory.
  always_ff @(posedge clk_i) begin
    if (nxt_we) begin
      nxt_mem[nxt_wa] <= nxt_wd;
    end
    if (cmd_i.rd_issue) begin
      nxt_rd_q <= nxt_mem[ent_q];
      nxt_rv_q <= nxt_vld_q[ent_q];
    end
  end

  // Previous-link memory.
  always_ff @(posedge clk_i) begin
    if (prv_we) begin
      prv_mem[prv_wa] <= prv_wd;
    end
    if (cmd_i.rd_issue) begin
      prv_rd_q <= prv_mem[ent_q];
      prv_rv_q <= prv_vld_q[ent_q];
    end
  end

  // Valid bits, count and list ends; a count write rebuilds the initial order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
      count_q   <= cnt_t'(MaxBlocks);
      lru_q     <= idx_t'(MaxBlocks - 1);
      mru_q     <= '0;
    end else if (cfg_we_i) begin
      nxt_vld_q <= '0;
      prv_vld_q <= '0;
      count_q   <= eff_count(cfg_data_i);
      lru_q     <= idx_t'(eff_count(cfg_data_i) - cnt_t'(1));
      mru_q     <= '0;
    end else begin
      if (nxt_we) begin
        nxt_vld_q[nxt_wa] <= 1'b1;
      end
      if (prv_we) begin
        prv_vld_q[prv_wa] <= 1'b1;
      end
      lru_q <= lru_d;
      mru_q <= mru_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_q.chosen_entry <= ent_q;
      out_q.fill_needed  <= item_q.mode;
      out_q.fill_addr    <= (item_q.mode == ModeMiss) ? item_q.source_addr : '0;
      out_q.bad_entry    <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/lru_replacement_list_top.sv -----
// Top level of the LRU replacement list: controller, datapath and checks.
`timescale 1ns / 1ps

// Keeps the least-recently-used order of up to 64 cache entries as a doubly linked
// list in two single-write-port link memories. A hit beat moves the named entry to
// the MRU end; a miss beat takes the LRU entry as victim, moves it to the MRU end and
// returns it with the address to fill. A hit at or above the entry count is flagged
// in bad_entry and changes nothing. Each request is worked on alone. A bad hit or a
// hit on the MRU entry goes from the look-up state straight to the done state. Any
// other request passes through the look-up, link and tail states; the next-link
// memory, which has a single write port, is written in the look-up and tail states
// and, unless the entry is the LRU one, in the link state. The done state waits for
// a free output register, and the next request is taken once the result sits in the output register. Writing cfg_data_i
// rebuilds the initial order at once (entry 0 MRU, highest entry LRU), so
// configuration must be written only while no request is in flight.
module lru_replacement_list_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  lrl_pkg::cnt_t     cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lrl_pkg::lrl_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lrl_pkg::lrl_out_t out_data_o
);
  import lrl_pkg::*;

  lrl_cmd_t cmd;
  lrl_sts_t sts;

  lrl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lrl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // After a beat is taken the block is busy until its result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while the previous one is still in work");

  // A result is never both a fill and a bad hit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.fill_needed && out_data_o.bad_entry))
    else $error("result flags a fill and a bad hit at once");

  // Without a fill the fill address is zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.fill_needed) |-> (out_data_o.fill_addr == '0))
    else $error("fill address set on a result without a fill");

  // The result register is loaded only when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_valid_o || out_ready_i))
    else $error("result loaded over a beat not yet taken");

endmodule
